// ===== hdl/bmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bowed mass-spring chain package
// Shared widths, register indexes, reset values and control structs.
// ----------------------------------------------------------------------------
package bmsc_pkg;

    localparam int POS_W      = 48;
    localparam int CELL_AW    = 56;
    localparam int TERM_W     = 56;
    localparam int MUL_BW     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748382;
    localparam logic [9:0]  OUT_GAIN     = 10'd1000;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOW_SCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOW_SHARPNESS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOW_FLOOR     = 3'd5;

    localparam logic [31:0] RST_DAMPING_GAIN  = 32'd779131;
    localparam logic [31:0] RST_DAMPING_SCALE = 32'd4294188306;
    localparam logic [17:0] RST_SAMPLE_RATE   = 18'd44100;
    localparam logic [31:0] RST_BOW_SCALE     = 32'd1696085;
    localparam logic [15:0] RST_BOW_SHARPNESS = 16'd256;
    localparam logic [15:0] RST_BOW_FLOOR     = 16'd328;

    typedef struct packed {
        logic [31:0] damping_gain;
        logic [31:0] damping_scale;
        logic [17:0] sample_rate;
        logic [31:0] bow_scale;
        logic [15:0] bow_sharpness;
        logic [15:0] bow_floor;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic commit;
    } t_step_ctl;

endpackage

// ===== hdl/bmsc_mul.sv =====
// ----------------------------------------------------------------------------
// Serial rounding multiplier
// Signed operand times unsigned 32 bit gain, two gain bits per cycle, then
// rounded to nearest (ties away from zero) after a right shift by SH.
// ----------------------------------------------------------------------------
module bmsc_mul import bmsc_pkg::*; #(
    parameter int AW = 56,
    parameter int SH = 32,
    parameter int RW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_a,
    input  logic [MUL_BW-1:0]    i_b,
    output logic                 o_done,
    output logic signed [RW-1:0] o_res
);

    localparam int PW    = AW + MUL_BW;
    localparam int NSTEP = MUL_BW / 2;
    localparam int CW    = $clog2(NSTEP + 1);

    logic              r_run;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic [PW-1:0]     r_m;
    logic [PW-1:0]     r_m3;
    logic [MUL_BW-1:0] r_b;
    logic [PW-1:0]     r_acc;
    logic signed [RW-1:0] r_res;

    logic [AW-1:0] w_mag;
    logic [PW-1:0] w_pp;
    logic [PW:0]   w_sum;
    logic [PW:0]   w_shr;
    logic [RW-1:0] w_rnd;

    assign w_mag = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);

    always_comb begin
        unique case (r_b[1:0])
            2'd0: w_pp = '0;
            2'd1: w_pp = r_m;
            2'd2: w_pp = r_m << 1;
            2'd3: w_pp = r_m3;
        endcase
    end

    assign w_sum = {1'b0, r_acc} + ({{PW{1'b0}}, 1'b1} << (SH - 1));
    assign w_shr = w_sum >> SH;
    assign w_rnd = w_shr[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_m    <= PW'(w_mag);
            r_m3   <= (PW'(w_mag) << 1) + PW'(w_mag);
            r_b    <= i_b;
            r_neg  <= i_a[AW-1];
        end else if (r_run) begin
            if (r_cnt == CW'(NSTEP)) begin
                r_res  <= r_neg ? -$signed(w_rnd) : $signed(w_rnd);
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_acc <= r_acc + w_pp;
                r_m   <= r_m << 2;
                r_m3  <= r_m3 << 2;
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hdl/bmsc_cell.sv =====
// ----------------------------------------------------------------------------
// Mass cell
// Holds one mass's current and previous displacement and computes its next
// displacement from the neighbor positions with one serial multiplier.
// ----------------------------------------------------------------------------
module bmsc_cell import bmsc_pkg::*; #(
    parameter bit HAS_RIGHT = 1'b1,
    parameter bit HAS_BOW   = 1'b0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_step_ctl                i_ctl,
    input  t_cfg                     i_cfg,
    input  logic [30:0]              i_spring_gain,
    input  logic signed [POS_W-1:0]  i_left,
    input  logic signed [POS_W-1:0]  i_right,
    input  logic                     i_bow_valid,
    input  logic signed [TERM_W-1:0] i_bow_term,
    output logic signed [POS_W-1:0]  o_pos,
    output logic signed [POS_W-1:0]  o_prev,
    output logic signed [POS_W-1:0]  o_next,
    output logic                     o_done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_L    = 3'd1;
    localparam logic [2:0] S_R    = 3'd2;
    localparam logic [2:0] S_D    = 3'd3;
    localparam logic [2:0] S_BOW  = 3'd4;
    localparam logic [2:0] S_ARG  = 3'd5;
    localparam logic [2:0] S_S    = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]                r_state;
    logic signed [POS_W-1:0]   r_pos;
    logic signed [POS_W-1:0]   r_prev;
    logic signed [POS_W-1:0]   r_next;
    logic signed [CELL_AW-1:0] r_f;
    logic                      r_go;
    logic signed [CELL_AW-1:0] r_ma;
    logic [MUL_BW-1:0]         r_mb;

    logic                      w_mdone;
    logic signed [CELL_AW-1:0] w_mres;
    logic signed [CELL_AW-1:0] w_dl;
    logic signed [CELL_AW-1:0] w_dr;
    logic signed [CELL_AW-1:0] w_arg;
    logic signed [POS_W-1:0]   w_sat;

    assign w_dl  = CELL_AW'(r_pos) - CELL_AW'(i_left);
    assign w_dr  = CELL_AW'(r_pos) - CELL_AW'(i_right);
    assign w_arg = r_f + (CELL_AW'(r_pos) <<< 1) - CELL_AW'(r_prev);

    always_comb begin
        if (w_mres > CELL_AW'(POS_MAX)) begin
            w_sat = POS_MAX;
        end else if (w_mres < CELL_AW'(POS_MIN)) begin
            w_sat = POS_MIN;
        end else begin
            w_sat = w_mres[POS_W-1:0];
        end
    end

    bmsc_mul #(
        .AW (CELL_AW),
        .SH (32),
        .RW (CELL_AW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_pos   <= '0;
            r_prev  <= '0;
        end else begin
            r_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_go    <= 1'b1;
                        r_ma    <= w_dl;
                        r_mb    <= MUL_BW'(i_spring_gain);
                        r_state <= S_L;
                    end
                end
                S_L: begin
                    if (w_mdone) begin
                        r_f  <= -w_mres;
                        r_go <= 1'b1;
                        if (HAS_RIGHT) begin
                            r_ma    <= w_dr;
                            r_mb    <= MUL_BW'(i_spring_gain);
                            r_state <= S_R;
                        end else begin
                            r_ma    <= CELL_AW'(r_prev);
                            r_mb    <= i_cfg.damping_gain;
                            r_state <= S_D;
                        end
                    end
                end
                S_R: begin
                    if (w_mdone) begin
                        r_f     <= r_f - w_mres;
                        r_go    <= 1'b1;
                        r_ma    <= CELL_AW'(r_prev);
                        r_mb    <= i_cfg.damping_gain;
                        r_state <= S_D;
                    end
                end
                S_D: begin
                    if (w_mdone) begin
                        r_f     <= r_f + w_mres;
                        r_state <= S_BOW;
                    end
                end
                S_BOW: begin
                    if (!HAS_BOW) begin
                        r_state <= S_ARG;
                    end else if (i_bow_valid) begin
                        r_f     <= r_f + CELL_AW'(i_bow_term);
                        r_state <= S_ARG;
                    end
                end
                S_ARG: begin
                    r_go    <= 1'b1;
                    r_ma    <= w_arg;
                    r_mb    <= i_cfg.damping_scale;
                    r_state <= S_S;
                end
                S_S: begin
                    if (w_mdone) begin
                        r_next  <= w_sat;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ctl.commit) begin
                        r_pos   <= r_next;
                        r_prev  <= r_pos;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_pos  = r_pos;
    assign o_prev = r_prev;
    assign o_next = r_next;
    assign o_done = (r_state == S_DONE);

endmodule

// ===== hdl/bmsc_bow.sv =====
// ----------------------------------------------------------------------------
// Bow friction unit
// Computes the bow force on the last mass from its velocity, an exponential
// friction curve held in a table that is built after reset, and the bow
// force and scale.
// ----------------------------------------------------------------------------
module bmsc_bow import bmsc_pkg::*; #(
    parameter int POS_FRAC_BITS   = 40,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_cfg                     i_cfg,
    input  logic [15:0]              i_bow_velocity,
    input  logic [14:0]              i_bow_force,
    input  logic signed [POS_W:0]    i_diff,
    output logic                     o_fill_done,
    output logic                     o_valid,
    output logic signed [TERM_W-1:0] o_term
);

    localparam int TAW     = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int SH_ETA  = POS_FRAC_BITS - 14;
    localparam int SH_TERM = 87 - POS_FRAC_BITS;

    localparam logic [3:0] B_FILL   = 4'd0;
    localparam logic [3:0] B_IDLE   = 4'd1;
    localparam logic [3:0] B_ETA    = 4'd2;
    localparam logic [3:0] B_MAG    = 4'd3;
    localparam logic [3:0] B_X      = 4'd4;
    localparam logic [3:0] B_LOOK   = 4'd5;
    localparam logic [3:0] B_INTERP = 4'd6;
    localparam logic [3:0] B_PHI    = 4'd7;
    localparam logic [3:0] B_TGO    = 4'd8;
    localparam logic [3:0] B_TERM   = 4'd9;

    logic [32:0] r_curve [0:EXP_TABLE_DEPTH];

    logic [3:0]               r_state;
    logic [TAW-1:0]           r_fcnt;
    logic [32:0]              r_fval;
    logic [15:0]              r_vb;
    logic [46:0]              r_g;
    logic signed [63:0]       r_eta;
    logic [31:0]              r_mag;
    logic [47:0]              r_x;
    logic                     r_beyond;
    logic [15:0]              r_frac;
    logic [32:0]              r_hi;
    logic [32:0]              r_lo;
    logic [32:0]              r_e;
    logic [31:0]              r_phi;
    logic                     r_valid;
    logic signed [TERM_W-1:0] r_term;

    logic [64:0]        w_fprod;
    logic [64:0]        w_fnext;
    logic               w_eta_done;
    logic signed [63:0] w_eta_res;
    logic               w_term_done;
    logic signed [63:0] w_term_res;
    logic [63:0]        w_eabs;
    logic [29:0]        w_idx;
    logic [TAW-1:0]     w_addr_hi;
    logic [TAW-1:0]     w_addr_lo;
    logic [32:0]        w_dlt;
    logic [48:0]        w_ip;
    logic [49:0]        w_pf;

    assign w_fprod = r_fval * EXP_STEP_Q32;
    assign w_fnext = (w_fprod + 65'h0_8000_0000) >> 32;

    assign w_eabs    = r_eta[63] ? 64'(-r_eta) : 64'(r_eta);
    assign w_idx     = r_x[47:18];
    assign w_addr_hi = r_x[18 +: TAW];
    assign w_addr_lo = w_addr_hi + TAW'(1);
    assign w_dlt     = r_hi - r_lo;
    assign w_ip      = w_dlt * r_frac;
    assign w_pf      = (17'd65536 - 17'(i_cfg.bow_floor)) * r_e;

    // Table build writes one entry per cycle; lookups read both neighbors.
    always_ff @(posedge i_clk) begin
        if (r_state == B_FILL) begin
            r_curve[r_fcnt] <= r_fval;
        end
        r_hi <= r_curve[w_addr_hi];
        r_lo <= r_curve[w_addr_lo];
    end

    bmsc_mul #(
        .AW (CELL_AW),
        .SH (SH_ETA),
        .RW (64)
    ) u_eta_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start && (r_state == B_IDLE)),
        .i_a     (CELL_AW'(i_diff)),
        .i_b     (MUL_BW'(i_cfg.sample_rate)),
        .o_done  (w_eta_done),
        .o_res   (w_eta_res)
    );

    bmsc_mul #(
        .AW (CELL_AW),
        .SH (SH_TERM),
        .RW (64)
    ) u_term_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == B_TGO),
        .i_a     ($signed(CELL_AW'(r_g))),
        .i_b     (r_phi),
        .o_done  (w_term_done),
        .o_res   (w_term_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_FILL;
            r_fcnt  <= '0;
            r_fval  <= 33'h1_0000_0000;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_FILL: begin
                    r_fval <= w_fnext[32:0];
                    if (r_fcnt == TAW'(EXP_TABLE_DEPTH)) begin
                        r_state <= B_IDLE;
                    end else begin
                        r_fcnt <= r_fcnt + 1'b1;
                    end
                end
                B_IDLE: begin
                    if (i_start) begin
                        r_vb    <= i_bow_velocity;
                        r_g     <= i_cfg.bow_scale * i_bow_force;
                        r_valid <= 1'b0;
                        r_state <= B_ETA;
                    end
                end
                B_ETA: begin
                    if (w_eta_done) begin
                        r_eta   <= w_eta_res - $signed({48'd0, r_vb});
                        r_state <= B_MAG;
                    end
                end
                B_MAG: begin
                    // No relative motion means no friction at all.
                    if (r_eta == '0) begin
                        r_term  <= '0;
                        r_valid <= 1'b1;
                        r_state <= B_IDLE;
                    end else begin
                        r_mag   <= (|w_eabs[63:32]) ? 32'hFFFF_FFFF : w_eabs[31:0];
                        r_state <= B_X;
                    end
                end
                B_X: begin
                    r_x     <= r_mag * i_cfg.bow_sharpness;
                    r_state <= B_LOOK;
                end
                B_LOOK: begin
                    r_beyond <= (w_idx >= 30'(EXP_TABLE_DEPTH));
                    r_frac   <= r_x[17:2];
                    r_state  <= B_INTERP;
                end
                B_INTERP: begin
                    r_e     <= r_beyond ? '0 : (r_hi - 33'(w_ip >> 16));
                    r_state <= B_PHI;
                end
                B_PHI: begin
                    r_phi   <= 32'({i_cfg.bow_floor, 15'd0}) + 32'(w_pf >> 17);
                    r_state <= B_TGO;
                end
                B_TGO: begin
                    r_state <= B_TERM;
                end
                B_TERM: begin
                    if (w_term_done) begin
                        // Friction opposes the relative velocity.
                        r_term  <= r_eta[63] ? TERM_W'(w_term_res) : TERM_W'(-w_term_res);
                        r_valid <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_fill_done = (r_state != B_FILL);
    assign o_valid     = r_valid;
    assign o_term      = r_term;

endmodule

// ===== hdl/bowed_mass_spring_chain.sv =====
// ----------------------------------------------------------------------------
// Bowed mass-spring chain
// Finite-difference chain of damped masses, bowed at the far end.
// ----------------------------------------------------------------------------
// Each request on the input stream is one audio tick. Every mass has its own
// cell with a serial multiplier (two gain bits per cycle), and the cells run
// side by side. An inner cell does four multiplies in turn and sets the pace.
// A new tick is taken once the previous result has been loaded into the
// output register. The bow unit runs alongside the cells. After reset the
// friction table is built one entry per cycle, and no tick is taken before
// it is complete; configuration writes are taken at any time.
module bowed_mass_spring_chain import bmsc_pkg::*; #(
    parameter int NUM_MASSES      = 3,
    parameter int POS_FRAC_BITS   = 40,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // bow_velocity [15:0], bow_force [30:16], spring_gain [61:31], zero [63:62]
    input  logic [63:0]           i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // sample [23:0]
    output logic [23:0]           o_m_axis_tdata,
    // clipped [0]
    output logic [0:0]            o_m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int OUT_SH = POS_FRAC_BITS - 23;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_OUT1 = 2'd2;
    localparam logic [1:0] C_OUT2 = 2'd3;

    t_cfg                    r_cfg;
    logic [1:0]              r_state;
    logic                    r_start;
    logic [15:0]             r_vb;
    logic [14:0]             r_bf;
    logic [30:0]             r_gain;
    logic signed [POS_W-1:0] r_n0;
    logic                    r_neg;
    logic [57:0]             r_oprod;
    logic                    r_ovalid;
    logic [23:0]             r_odata;
    logic                    r_oclip;

    t_step_ctl               w_ctl;
    logic                    w_in_acc;
    logic                    w_fill_done;
    logic                    w_bow_valid;
    logic signed [TERM_W-1:0] w_bow_term;
    logic signed [POS_W-1:0] w_pos  [NUM_MASSES];
    logic signed [POS_W-1:0] w_prev [NUM_MASSES];
    logic signed [POS_W-1:0] w_next [NUM_MASSES];
    logic [NUM_MASSES-1:0]   w_done;
    logic                    w_all_done;
    logic signed [POS_W:0]   w_diff;
    logic [POS_W-1:0]        w_n0_mag;
    logic [58:0]             w_round;
    logic                    w_load;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == C_IDLE) && w_fill_done;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_all_done      = &w_done;
    assign w_ctl.start     = r_start;
    assign w_ctl.commit    = (r_state == C_RUN) && w_all_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.damping_gain  <= RST_DAMPING_GAIN;
            r_cfg.damping_scale <= RST_DAMPING_SCALE;
            r_cfg.sample_rate   <= RST_SAMPLE_RATE;
            r_cfg.bow_scale     <= RST_BOW_SCALE;
            r_cfg.bow_sharpness <= RST_BOW_SHARPNESS;
            r_cfg.bow_floor     <= RST_BOW_FLOOR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DAMPING_GAIN:  r_cfg.damping_gain  <= i_cfg_data;
                REG_DAMPING_SCALE: r_cfg.damping_scale <= i_cfg_data;
                REG_SAMPLE_RATE:   r_cfg.sample_rate   <= i_cfg_data[17:0];
                REG_BOW_SCALE:     r_cfg.bow_scale     <= i_cfg_data;
                REG_BOW_SHARPNESS: r_cfg.bow_sharpness <= i_cfg_data[15:0];
                REG_BOW_FLOOR:     r_cfg.bow_floor     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_MASSES; gi++) begin : g_cell
            logic signed [POS_W-1:0] w_left;
            logic signed [POS_W-1:0] w_right;
            if (gi == 0) begin : g_ground
                assign w_left = '0;
            end else begin : g_left
                assign w_left = w_pos[gi-1];
            end
            if (gi == NUM_MASSES - 1) begin : g_end
                assign w_right = '0;
            end else begin : g_right
                assign w_right = w_pos[gi+1];
            end
            bmsc_cell #(
                .HAS_RIGHT (gi != NUM_MASSES - 1),
                .HAS_BOW   (gi == NUM_MASSES - 1)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_cfg         (r_cfg),
                .i_spring_gain (r_gain),
                .i_left        (w_left),
                .i_right       (w_right),
                .i_bow_valid   (w_bow_valid),
                .i_bow_term    (w_bow_term),
                .o_pos         (w_pos[gi]),
                .o_prev        (w_prev[gi]),
                .o_next        (w_next[gi]),
                .o_done        (w_done[gi])
            );
        end
    endgenerate

    assign w_diff = (POS_W+1)'(w_pos[NUM_MASSES-1]) - (POS_W+1)'(w_prev[NUM_MASSES-1]);

    bmsc_bow #(
        .POS_FRAC_BITS   (POS_FRAC_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_bow (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (r_start),
        .i_cfg          (r_cfg),
        .i_bow_velocity (r_vb),
        .i_bow_force    (r_bf),
        .i_diff         (w_diff),
        .o_fill_done    (w_fill_done),
        .o_valid        (w_bow_valid),
        .o_term         (w_bow_term)
    );

    assign w_n0_mag = r_n0[POS_W-1] ? POS_W'(-r_n0) : POS_W'(r_n0);
    assign w_round  = ({1'b0, r_oprod} + (59'd1 << (OUT_SH - 1))) >> OUT_SH;
    assign w_load   = (r_state == C_OUT2) && (!r_ovalid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (w_in_acc) begin
                        r_vb    <= i_s_axis_tdata[15:0];
                        r_bf    <= i_s_axis_tdata[30:16];
                        r_gain  <= i_s_axis_tdata[61:31];
                        r_start <= 1'b1;
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    if (w_all_done) begin
                        r_n0    <= w_next[0];
                        r_state <= C_OUT1;
                    end
                end
                C_OUT1: begin
                    r_neg   <= r_n0[POS_W-1];
                    r_oprod <= w_n0_mag * OUT_GAIN;
                    r_state <= C_OUT2;
                end
                C_OUT2: begin
                    if (w_load) begin
                        r_state <= C_IDLE;
                    end
                end
            endcase

            if (w_load) begin
                r_ovalid <= 1'b1;
                if (!r_neg && (w_round > 59'd8388607)) begin
                    r_odata <= 24'h7F_FFFF;
                    r_oclip <= 1'b1;
                end else if (r_neg && (w_round > 59'd8388608)) begin
                    r_odata <= 24'h80_0000;
                    r_oclip <= 1'b1;
                end else begin
                    r_odata <= r_neg ? -w_round[23:0] : w_round[23:0];
                    r_oclip <= 1'b0;
                end
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_oclip;

endmodule
